### hdl/flvtd_pkg.sv
// ----------------------------------------------------------------------------
// FLV tag demultiplexer package
// Shared constants, the result record and the signature lookup.
// ----------------------------------------------------------------------------
package flvtd_pkg;

   localparam int unsigned CountWidth = 24;

   localparam logic [CountWidth-1:0] FILE_HDR_LAST = 24'd12;
   localparam logic [CountWidth-1:0] TAG_HDR_LAST  = 24'd10;
   localparam logic [CountWidth-1:0] TRAILER_LAST  = 24'd3;
   localparam logic [CountWidth-1:0] SIG_LEN       = 24'd3;
   localparam logic [31:0]           TAG_HDR_LEN   = 32'd11;

   localparam logic [7:0] KIND_AUDIO = 8'h08;
   localparam logic [7:0] KIND_VIDEO = 8'h09;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TRAILER   = 2'd1;
   localparam logic [1:0] ST_SIGNATURE = 2'd2;

   typedef struct packed {
      logic        valid;
      logic [7:0]  payload_byte;
      logic        media_kind;
      logic [23:0] tag_time;
      logic        last_of_tag;
      logic [1:0]  status;
   } rsp_type;

   function automatic logic [7:0] sig_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h46;
         2'd1:    b = 8'h4C;
         2'd2:    b = 8'h56;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

### hdl/flvtd_in_reg.sv
// ----------------------------------------------------------------------------
// FLV tag demultiplexer input register
// Holds one accepted input beat until the parser can take it.
// ----------------------------------------------------------------------------
module flvtd_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       out_free,
   output logic       advance,
   output logic [7:0] beat_byte
);

   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       load;

   assign advance   = valid_ff && out_free;
   assign load      = !valid_ff || advance;
   assign req_stall = !load;
   assign beat_byte = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         byte_ff <= req_data_byte;
      end
   end

endmodule

### hdl/flvtd_parser.sv
// ----------------------------------------------------------------------------
// FLV tag demultiplexer parser
// Tracks the stream position and builds one result record per beat.
// ----------------------------------------------------------------------------
module flvtd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          beat_byte,
   input  logic                csr_we,
   input  logic                csr_expect_file_header,
   output flvtd_pkg::rsp_type  res
);

   localparam logic [2:0] PH_FILE_HDR = 3'd0;
   localparam logic [2:0] PH_TAG_HDR  = 3'd1;
   localparam logic [2:0] PH_BODY     = 3'd2;
   localparam logic [2:0] PH_TRAILER  = 3'd3;
   localparam logic [2:0] PH_HALT     = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [23:0] count_ff, count_in;
   logic [7:0]  kind_ff, kind_in;
   logic [23:0] length_ff, length_in;
   logic [23:0] stamp_ff, stamp_in;
   logic [31:0] trailer_ff, trailer_in;
   logic        expect_ff, expect_in;
   logic        body_last;
   logic [24:0] count_next;

   assign count_next = {1'b0, count_ff} + 25'd1;
   assign body_last  = count_next >= {1'b0, length_ff};

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      kind_in    = kind_ff;
      length_in  = length_ff;
      stamp_in   = stamp_ff;
      trailer_in = trailer_ff;
      expect_in  = expect_ff;
      res        = '0;
      if (advance) begin
         case (phase_ff)
            PH_FILE_HDR: begin
               if (count_ff < flvtd_pkg::SIG_LEN &&
                   beat_byte != flvtd_pkg::sig_byte(count_ff[1:0])) begin
                  phase_in   = PH_HALT;
                  res.valid  = 1'b1;
                  res.status = flvtd_pkg::ST_SIGNATURE;
               end else if (count_ff == flvtd_pkg::FILE_HDR_LAST) begin
                  count_in = '0;
                  phase_in = PH_TAG_HDR;
               end else begin
                  count_in = count_next[23:0];
               end
            end
            PH_TAG_HDR: begin
               if (count_ff == '0) begin
                  kind_in   = beat_byte;
                  length_in = '0;
                  stamp_in  = '0;
               end else if (count_ff inside {[24'd1:24'd3]}) begin
                  length_in = {length_ff[15:0], beat_byte};
               end else if (count_ff inside {[24'd4:24'd6]}) begin
                  stamp_in = {stamp_ff[15:0], beat_byte};
               end
               if (count_ff == flvtd_pkg::TAG_HDR_LAST) begin
                  count_in   = '0;
                  trailer_in = '0;
                  phase_in   = (length_ff == '0) ? PH_TRAILER : PH_BODY;
               end else begin
                  count_in = count_next[23:0];
               end
            end
            PH_BODY: begin
               if (kind_ff == flvtd_pkg::KIND_AUDIO || kind_ff == flvtd_pkg::KIND_VIDEO) begin
                  res.valid        = 1'b1;
                  res.payload_byte = beat_byte;
                  res.media_kind   = (kind_ff == flvtd_pkg::KIND_VIDEO);
                  res.tag_time     = stamp_ff;
                  res.last_of_tag  = body_last;
                  res.status       = flvtd_pkg::ST_OK;
               end
               if (body_last) begin
                  count_in   = '0;
                  trailer_in = '0;
                  phase_in   = PH_TRAILER;
               end else begin
                  count_in = count_next[23:0];
               end
            end
            PH_TRAILER: begin
               trailer_in = {trailer_ff[23:0], beat_byte};
               if (count_ff == flvtd_pkg::TRAILER_LAST) begin
                  count_in = '0;
                  if (trailer_in != {8'd0, length_ff} + flvtd_pkg::TAG_HDR_LEN) begin
                     phase_in   = PH_HALT;
                     res.valid  = 1'b1;
                     res.status = flvtd_pkg::ST_TRAILER;
                  end else begin
                     phase_in = PH_TAG_HDR;
                  end
               end else begin
                  count_in = count_next[23:0];
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
      if (csr_we) begin
         expect_in = csr_expect_file_header;
         if ((phase_ff == PH_FILE_HDR || phase_ff == PH_TAG_HDR) && count_ff == '0) begin
            phase_in = csr_expect_file_header ? PH_FILE_HDR : PH_TAG_HDR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_FILE_HDR;
         count_ff   <= '0;
         kind_ff    <= '0;
         length_ff  <= '0;
         stamp_ff   <= '0;
         trailer_ff <= '0;
         expect_ff  <= 1'b1;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         kind_ff    <= kind_in;
         length_ff  <= length_in;
         stamp_ff   <= stamp_in;
         trailer_ff <= trailer_in;
         expect_ff  <= expect_in;
      end
   end

`ifndef SYNTHESIS
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |-> !res.valid)
      else $error("Result produced while halted.");

   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (res.valid && res.status != flvtd_pkg::ST_OK && !csr_we) |=> phase_ff == PH_HALT)
      else $error("Error result did not halt the parser.");

   a_file_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_FILE_HDR |-> count_ff <= flvtd_pkg::FILE_HDR_LAST)
      else $error("File header count out of range.");

   a_result_needs_beat: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> advance)
      else $error("Result without an input beat.");
`endif

endmodule

### hdl/flvtd_out_reg.sv
// ----------------------------------------------------------------------------
// FLV tag demultiplexer result register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module flvtd_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  flvtd_pkg::rsp_type res,
   output logic               out_free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_payload_byte,
   output logic               rsp_media_kind,
   output logic [23:0]        rsp_tag_time,
   output logic               rsp_last_of_tag,
   output logic [1:0]         rsp_status
);

   flvtd_pkg::rsp_type rsp_ff;

   assign out_free         = !rsp_ff.valid || !rsp_stall;
   assign rsp_valid        = rsp_ff.valid;
   assign rsp_payload_byte = rsp_ff.payload_byte;
   assign rsp_media_kind   = rsp_ff.media_kind;
   assign rsp_tag_time     = rsp_ff.tag_time;
   assign rsp_last_of_tag  = rsp_ff.last_of_tag;
   assign rsp_status       = rsp_ff.status;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else if (out_free) begin
         rsp_ff.valid <= res.valid;
      end
      if (out_free && res.valid) begin
         rsp_ff.payload_byte <= res.payload_byte;
         rsp_ff.media_kind   <= res.media_kind;
         rsp_ff.tag_time     <= res.tag_time;
         rsp_ff.last_of_tag  <= res.last_of_tag;
         rsp_ff.status       <= res.status;
      end
   end

endmodule

### hdl/flv_tag_demux.sv
// ----------------------------------------------------------------------------
// FLV tag demultiplexer
// Splits an FLV byte stream into audio and video body beats.
// ----------------------------------------------------------------------------
// Usage: each req beat carries one stream byte on req_data_byte. Each rsp
// beat carries one audio or video body byte with its kind, tag timestamp
// and a last flag, or a single error beat (bad signature or trailing size
// mismatch) after which the block ignores all input until reset.
// Header, trailer and non-media body bytes give no rsp beat.
// The csr channel writes expect_file_header; csr_ready is always high and
// writes belong between streams, while the block is idle.
// A byte accepted into the input register is parsed into the result register,
// from which its rsp beat is taken.
// Throughput: one byte per cycle, set by the single parse stage, unless stalled.
// When rsp_stall is high with a beat held, the result register holds; the input
// register takes one more byte only if empty, after which req_stall rises.
// Reset empties both registers and returns the parser to the file header
// phase with expect_file_header set.
// ----------------------------------------------------------------------------
module flv_tag_demux (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_media_kind,
   output logic [23:0] rsp_tag_time,
   output logic        rsp_last_of_tag,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_expect_file_header
);

   logic               out_free;
   logic               advance;
   logic [7:0]         beat_byte;
   flvtd_pkg::rsp_type res;

   assign csr_ready = 1'b1;

   flvtd_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .out_free      (out_free),
      .advance       (advance),
      .beat_byte     (beat_byte)
   );

   flvtd_parser u_parser (
      .clock                  (clock),
      .reset                  (reset),
      .advance                (advance),
      .beat_byte              (beat_byte),
      .csr_we                 (csr_valid && csr_ready),
      .csr_expect_file_header (csr_expect_file_header),
      .res                    (res)
   );

   flvtd_out_reg u_out_reg (
      .clock            (clock),
      .reset            (reset),
      .res              (res),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_media_kind   (rsp_media_kind),
      .rsp_tag_time     (rsp_tag_time),
      .rsp_last_of_tag  (rsp_last_of_tag),
      .rsp_status       (rsp_status)
   );

endmodule
